### design/frtm_pkg.sv
// Shared types and constants of the frame receive timeout monitor.
package frtm_pkg;

	localparam int DEF_TABLE_DEPTH = 16;
	localparam int CH_W            = 8;
	localparam int ID_W            = 32;
	localparam int TIME_W          = 32;
	localparam int CNT_W           = 32;
	localparam int IDX_OUT_W       = 4;
	localparam int USED_OUT_W      = 5;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_RECEIVE  = 2'd1,
		OP_TICK     = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_DONE       = 3'd0,
		KIND_REGISTERED = 3'd1,
		KIND_FULL       = 3'd2,
		KIND_EXPIRED    = 3'd3,
		KIND_NO_MATCH   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		IDX_NONE = 2'd0,
		IDX_FILL = 2'd1,
		IDX_CHK  = 2'd2
	} idx_sel_t;

	typedef struct packed {
		logic              timed_out;
		logic [TIME_W-1:0] last_seen;
		logic [TIME_W-1:0] deadline;
		logic [ID_W-1:0]   frame;
		logic [CH_W-1:0]   channel;
	} entry_t;

	typedef struct packed {
		logic     cap;
		logic     scan_go;
		logic     scan_run;
		logic     scan_rx;
		logic     do_reg;
		logic     do_clr;
		logic     wb;
		logic     cnt_inc;
		logic     emit;
		kind_t    kind;
		idx_sel_t idx_sel;
		logic     last;
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
		logic fill_zero;
		logic enabled;
		logic rx_hit;
		logic tk_hit;
		logic scan_end;
	} dp_sts_t;

endpackage

### design/frame_receive_timeout_monitor.sv
// Top level of the frame receive timeout monitor: controller plus datapath.
//
// Items are taken when start is high and busy is low. Register and clear give
// their single result word on the next cycle, with busy staying low, so they
// can be issued back to back. Receive and tick walk the filled slots of the
// table through its single read port, one slot per cycle: busy stays high
// until the last filled slot is checked (through a closing state when a tick's
// last slot expires), and the scan ends early when a receive matches. A
// receive on an empty table, or a tick with the monitor disabled or the table
// empty, answers like a register. Each result word is driven for exactly one
// cycle with result_valid; the receiver cannot stall, so it must take every
// word as it comes. A tick delivers its expiry words in slot order, one per
// cycle at most, and ends with a done word carrying last. The configuration
// channel is always ready and should only be written while busy is low and no
// result is pending.
module frame_receive_timeout_monitor import frtm_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            opcode,
	input  logic [CH_W-1:0]       channel_id,
	input  logic [ID_W-1:0]       frame_id,
	input  logic [TIME_W-1:0]     timeout_ms,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic                  cfg_data,
	output logic                  result_valid,
	output logic [2:0]            kind,
	output logic [IDX_OUT_W-1:0]  entry_index,
	output logic [CH_W-1:0]       expired_channel,
	output logic [ID_W-1:0]       expired_frame_id,
	output logic [CNT_W-1:0]      timeout_total,
	output logic [USED_OUT_W-1:0] entries_used,
	output logic                  last
);

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	assign cfg_ready = 1'b1;

	frtm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	frtm_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_valid        (cfg_valid && cfg_ready),
		.cfg_data         (cfg_data),
		.channel_id       (channel_id),
		.frame_id         (frame_id),
		.timeout_ms       (timeout_ms),
		.now_ms           (now_ms),
		.result_valid     (result_valid),
		.kind             (kind),
		.entry_index      (entry_index),
		.expired_channel  (expired_channel),
		.expired_frame_id (expired_frame_id),
		.timeout_total    (timeout_total),
		.entries_used     (entries_used),
		.last             (last)
	);

endmodule

### design/frtm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module frtm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### design/frtm_datapath.sv
// Datapath: slot table, fill level, expiry counter, scan pipeline and result registers.
module frtm_datapath import frtm_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output dp_sts_t               sts,
	input  logic                  cfg_valid,
	input  logic                  cfg_data,
	input  logic [CH_W-1:0]       channel_id,
	input  logic [ID_W-1:0]       frame_id,
	input  logic [TIME_W-1:0]     timeout_ms,
	input  logic [TIME_W-1:0]     now_ms,
	output logic                  result_valid,
	output logic [2:0]            kind,
	output logic [IDX_OUT_W-1:0]  entry_index,
	output logic [CH_W-1:0]       expired_channel,
	output logic [ID_W-1:0]       expired_frame_id,
	output logic [CNT_W-1:0]      timeout_total,
	output logic [USED_OUT_W-1:0] entries_used,
	output logic                  last
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FW = $clog2(TABLE_DEPTH + 1);
	localparam int EW = $bits(entry_t);

	logic [FW-1:0]     fill_q, fill_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              enabled_q;
	logic [FW-1:0]     rd_ptr_q;
	logic              chk_vld_s1;
	logic [AW-1:0]     chk_idx_s1;
	logic [CH_W-1:0]   ch_q;
	logic [ID_W-1:0]   fr_q;
	logic [TIME_W-1:0] now_q;

	logic              rd_more;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	entry_t            ram_wdata;
	logic [EW-1:0]     ram_rdata;
	entry_t            rd_e;
	entry_t            new_e;
	entry_t            wb_e;
	logic              rx_match;
	logic              tk_exp;
	logic [TIME_W-1:0] elapsed;
	logic [AW-1:0]     idx_pick;
	logic [AW+IDX_OUT_W-1:0]  idx_ext;
	logic [FW+USED_OUT_W-1:0] used_ext;

	assign rd_e    = entry_t'(ram_rdata);
	assign rd_more = rd_ptr_q < fill_q;
	assign elapsed = now_q - rd_e.last_seen;

	assign rx_match = (rd_e.channel == ch_q) && (rd_e.frame == fr_q);
	assign tk_exp   = !rd_e.timed_out && (rd_e.deadline != '0) && (elapsed >= rd_e.deadline);

	// status comes from registers only; the controller looks at it in idle and while scanning
	assign sts.full      = fill_q == FW'(TABLE_DEPTH);
	assign sts.fill_zero = fill_q == '0;
	assign sts.enabled   = enabled_q;
	assign sts.rx_hit    = chk_vld_s1 && rx_match;
	assign sts.tk_hit    = chk_vld_s1 && tk_exp;
	assign sts.scan_end  = chk_vld_s1 && (FW'(chk_idx_s1) == fill_q - FW'(1));

	always_comb begin
		new_e           = '0;
		new_e.deadline  = timeout_ms;
		new_e.frame     = frame_id;
		new_e.channel   = channel_id;
		wb_e            = rd_e;
		if (cmd.scan_rx) begin
			wb_e.last_seen = now_q;
			wb_e.timed_out = 1'b0;
		end else begin
			wb_e.timed_out = 1'b1;
		end
	end

	// registration writes only from idle, writeback only while scanning
	assign ram_we    = cmd.do_reg || cmd.wb;
	assign ram_waddr = cmd.wb ? chk_idx_s1 : fill_q[AW-1:0];
	assign ram_wdata = cmd.wb ? wb_e : new_e;

	frtm_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.scan_run && rd_more),
		.raddr (rd_ptr_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		fill_d = fill_q;
		if (cmd.do_clr) begin
			fill_d = '0;
		end else if (cmd.do_reg) begin
			fill_d = fill_q + FW'(1);
		end
		cnt_d = cnt_q;
		if (cmd.do_clr) begin
			cnt_d = '0;
		end else if (cmd.cnt_inc) begin
			cnt_d = cnt_q + CNT_W'(1);
		end
	end

	always_comb begin
		case (cmd.idx_sel)
			IDX_FILL: idx_pick = fill_q[AW-1:0];
			IDX_CHK:  idx_pick = chk_idx_s1;
			default:  idx_pick = '0;
		endcase
	end

	// indexes and fill level are masked to the result field widths
	assign idx_ext  = {{IDX_OUT_W{1'b0}}, idx_pick};
	assign used_ext = {{USED_OUT_W{1'b0}}, fill_d};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			cnt_q        <= '0;
			enabled_q    <= 1'b0;
			rd_ptr_q     <= '0;
			chk_vld_s1   <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			fill_q       <= fill_d;
			cnt_q        <= cnt_d;
			result_valid <= cmd.emit;
			if (cfg_valid) begin
				enabled_q <= cfg_data;
			end
			if (cmd.scan_go) begin
				rd_ptr_q   <= '0;
				chk_vld_s1 <= 1'b0;
			end else begin
				chk_vld_s1 <= cmd.scan_run && rd_more;
				if (cmd.scan_run && rd_more) begin
					rd_ptr_q <= rd_ptr_q + FW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			ch_q  <= channel_id;
			fr_q  <= frame_id;
			now_q <= now_ms;
		end
		if (cmd.scan_run && rd_more && !cmd.scan_go) begin
			chk_idx_s1 <= rd_ptr_q[AW-1:0];
		end
		if (cmd.emit) begin
			kind          <= cmd.kind;
			entry_index   <= idx_ext[IDX_OUT_W-1:0];
			timeout_total <= cnt_d;
			entries_used  <= used_ext[USED_OUT_W-1:0];
			last          <= cmd.last;
			if (cmd.kind == KIND_EXPIRED) begin
				expired_channel  <= rd_e.channel;
				expired_frame_id <= rd_e.frame;
			end else begin
				expired_channel  <= '0;
				expired_frame_id <= '0;
			end
		end
	end

endmodule

### design/frtm_ctrl.sv
// Controller: decodes accepted items and sequences the slot scan.
module frtm_ctrl import frtm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] opcode,
	input  dp_sts_t    sts,
	output ctl_cmd_t   cmd,
	output logic       busy
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   rx_q, rx_d;

	assign busy = state_q != ST_IDLE;

	always_comb begin
		state_d      = state_q;
		rx_d         = rx_q;
		cmd          = '0;
		cmd.kind     = KIND_DONE;
		cmd.idx_sel  = IDX_NONE;
		cmd.scan_rx  = rx_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (op_t'(opcode))
						OP_REGISTER: begin
							cmd.emit = 1'b1;
							cmd.last = 1'b1;
							if (sts.full) begin
								cmd.kind = KIND_FULL;
							end else begin
								cmd.do_reg  = 1'b1;
								cmd.kind    = KIND_REGISTERED;
								cmd.idx_sel = IDX_FILL;
							end
						end
						OP_RECEIVE: begin
							cmd.cap     = 1'b1;
							cmd.scan_go = 1'b1;
							if (sts.fill_zero) begin
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
								cmd.kind = KIND_NO_MATCH;
							end else begin
								rx_d    = 1'b1;
								state_d = ST_SCAN;
							end
						end
						OP_TICK: begin
							cmd.cap     = 1'b1;
							cmd.scan_go = 1'b1;
							if (!sts.enabled || sts.fill_zero) begin
								cmd.emit = 1'b1;
								cmd.last = 1'b1;
							end else begin
								rx_d    = 1'b0;
								state_d = ST_SCAN;
							end
						end
						default: begin
							cmd.do_clr = 1'b1;
							cmd.emit   = 1'b1;
							cmd.last   = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (rx_q ? sts.rx_hit : sts.tk_hit) begin
					cmd.wb      = 1'b1;
					cmd.emit    = 1'b1;
					cmd.idx_sel = IDX_CHK;
					if (rx_q) begin
						cmd.kind = KIND_DONE;
						cmd.last = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						cmd.kind    = KIND_EXPIRED;
						cmd.cnt_inc = 1'b1;
						// closing word of the tick follows in its own cycle
						if (sts.scan_end) begin
							state_d = ST_FIN;
						end
					end
				end else if (sts.scan_end) begin
					cmd.emit = 1'b1;
					cmd.last = 1'b1;
					cmd.kind = rx_q ? KIND_NO_MATCH : KIND_DONE;
					state_d  = ST_IDLE;
				end
			end
			ST_FIN: begin
				cmd.emit = 1'b1;
				cmd.last = 1'b1;
				state_d  = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rx_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rx_q    <= rx_d;
		end
	end

endmodule

### tb/sv/frame_receive_timeout_monitor_tb.sv
// Self-checking bench for the frame receive timeout monitor: table, receive, tick and clear.
module frame_receive_timeout_monitor_tb;
	import frtm_pkg::*;

	localparam int DEPTH = DEF_TABLE_DEPTH;

	typedef struct {
		kind_t                 kind;
		logic [IDX_OUT_W-1:0]  idx;
		logic [CH_W-1:0]       ch;
		logic [ID_W-1:0]       fr;
		logic [CNT_W-1:0]      total;
		logic [USED_OUT_W-1:0] used;
		logic                  last;
	} report_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            opcode;
	logic [CH_W-1:0]       channel_id;
	logic [ID_W-1:0]       frame_id;
	logic [TIME_W-1:0]     timeout_ms;
	logic [TIME_W-1:0]     now_ms;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic                  cfg_data;
	logic                  result_valid;
	logic [2:0]            kind;
	logic [IDX_OUT_W-1:0]  entry_index;
	logic [CH_W-1:0]       expired_channel;
	logic [ID_W-1:0]       expired_frame_id;
	logic [CNT_W-1:0]      timeout_total;
	logic [USED_OUT_W-1:0] entries_used;
	logic                  last;

	// shadow of the deadline table
	logic [CH_W-1:0]   tbl_channel[DEPTH];
	logic [ID_W-1:0]   tbl_frame[DEPTH];
	logic [TIME_W-1:0] tbl_deadline[DEPTH];
	logic [TIME_W-1:0] tbl_last_seen[DEPTH];
	logic              tbl_timed_out[DEPTH];
	int                tbl_fill = 0;
	logic [CNT_W-1:0]  tbl_expiries = '0;
	logic              tbl_enabled = 1'b0;

	report_t           due_reports[$];
	int                mismatch_count = 0;
	int                burst_left = 0;
	logic [TIME_W-1:0] clock_ms = '0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	frame_receive_timeout_monitor #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.channel_id(channel_id),
		.frame_id(frame_id),
		.timeout_ms(timeout_ms),
		.now_ms(now_ms),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.kind(kind),
		.entry_index(entry_index),
		.expired_channel(expired_channel),
		.expired_frame_id(expired_frame_id),
		.timeout_total(timeout_total),
		.entries_used(entries_used),
		.last(last)
	);

	// counter and fill level are taken after the state change of the word
	function automatic void queue_report(kind_t k, int idx, logic [CH_W-1:0] ch,
			logic [ID_W-1:0] fr, logic lst);
		report_t r;
		r.kind  = k;
		r.idx   = idx[IDX_OUT_W-1:0];
		r.ch    = ch;
		r.fr    = fr;
		r.total = tbl_expiries;
		r.used  = tbl_fill[USED_OUT_W-1:0];
		r.last  = lst;
		due_reports = {due_reports, r};
	endfunction

	function automatic void predict_reports(op_t op, logic [CH_W-1:0] ch, logic [ID_W-1:0] fr,
			logic [TIME_W-1:0] to, logic [TIME_W-1:0] now);
		int                i;
		int                hit;
		logic [TIME_W-1:0] age;
		case (op)
			OP_REGISTER: begin
				if (tbl_fill < DEPTH) begin
					tbl_channel[tbl_fill]   = ch;
					tbl_frame[tbl_fill]     = fr;
					tbl_deadline[tbl_fill]  = to;
					tbl_last_seen[tbl_fill] = '0;
					tbl_timed_out[tbl_fill] = 1'b0;
					tbl_fill++;
					queue_report(KIND_REGISTERED, tbl_fill - 1, '0, '0, 1'b1);
				end else begin
					queue_report(KIND_FULL, 0, '0, '0, 1'b1);
				end
			end
			OP_RECEIVE: begin
				hit = -1;
				for (i = 0; i < tbl_fill; i++)
					if (hit < 0 && tbl_channel[i] == ch && tbl_frame[i] == fr)
						hit = i;
				if (hit >= 0) begin
					tbl_last_seen[hit] = now;
					tbl_timed_out[hit] = 1'b0;
					queue_report(KIND_DONE, hit, '0, '0, 1'b1);
				end else begin
					queue_report(KIND_NO_MATCH, 0, '0, '0, 1'b1);
				end
			end
			OP_TICK: begin
				if (tbl_enabled) begin
					for (i = 0; i < tbl_fill; i++) begin
						age = now - tbl_last_seen[i];
						if (!tbl_timed_out[i] && tbl_deadline[i] != 0 && age >= tbl_deadline[i]) begin
							tbl_timed_out[i] = 1'b1;
							tbl_expiries++;
							queue_report(KIND_EXPIRED, i, tbl_channel[i], tbl_frame[i], 1'b0);
						end
					end
				end
				queue_report(KIND_DONE, 0, '0, '0, 1'b1);
			end
			default: begin
				tbl_fill     = 0;
				tbl_expiries = '0;
				queue_report(KIND_DONE, 0, '0, '0, 1'b1);
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		report_t want;
		if (arst_n && result_valid) begin
			if (due_reports.size() == 0) begin
				mismatch_count++;
				$display("%0t: result word with none expected, expected none, actual kind %0d",
					$time, kind);
			end else begin
				want = due_reports.pop_front();
				check_field("kind", want.kind, kind);
				check_field("entry_index", want.idx, entry_index);
				check_field("expired_channel", want.ch, expired_channel);
				check_field("expired_frame_id", want.fr, expired_frame_id);
				check_field("timeout_total", want.total, timeout_total);
				check_field("entries_used", want.used, entries_used);
				check_field("last", want.last, last);
			end
		end
	end

	// one command word; start stays high when the next word follows in the same burst
	task automatic send_word(op_t op, logic [CH_W-1:0] ch, logic [ID_W-1:0] fr,
			logic [TIME_W-1:0] to, logic [TIME_W-1:0] now);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
		end
		burst_left--;
		start      <= 1'b1;
		opcode     <= op;
		channel_id <= ch;
		frame_id   <= fr;
		timeout_ms <= to;
		now_ms     <= now;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_reports(op, ch, fr, to, now);
	endtask

	task automatic drain();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (due_reports.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_enable(logic en);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= en;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		tbl_enabled = en;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed_cases();
		write_enable(1'b0);
		send_word(OP_TICK, 8'h00, 32'h0, 32'h0, 32'h0);
		send_word(OP_RECEIVE, 8'h00, 32'h0, 32'h0, 32'h0);
		send_word(OP_REGISTER, 8'h00, 32'h0000_0000, 32'h0000_0000, 32'h0);
		send_word(OP_REGISTER, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(OP_REGISTER, 8'hA5, 32'h5A5A_5A5A, 32'h0000_0001, 32'h0);
		// duplicate of the previous entry, only the first one gets receives
		send_word(OP_REGISTER, 8'hA5, 32'h5A5A_5A5A, 32'h0000_000A, 32'h0);
		send_word(OP_RECEIVE, 8'hFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFF0);
		send_word(OP_RECEIVE, 8'hFF, 32'h0000_0000, 32'h0, 32'h5);
		send_word(OP_TICK, 8'h00, 32'h0, 32'h0, 32'd100);
		write_enable(1'b1);
		send_word(OP_TICK, 8'h00, 32'h0, 32'h0, 32'd0);
		send_word(OP_TICK, 8'h00, 32'h0, 32'h0, 32'd1);
		send_word(OP_RECEIVE, 8'hA5, 32'h5A5A_5A5A, 32'h0, 32'd2);
		send_word(OP_TICK, 8'h00, 32'h0, 32'h0, 32'd12);
		send_word(OP_TICK, 8'h00, 32'h0, 32'h0, 32'd12);
		// elapsed time wraps past zero to the largest timeout
		send_word(OP_TICK, 8'h00, 32'h0, 32'h0, 32'hFFFF_FFEF);
		send_word(OP_CLEAR, 8'h00, 32'h0, 32'h0, 32'h0);
		send_word(OP_RECEIVE, 8'hFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
	endtask

	task automatic test_full_table();
		repeat (DEPTH + 2)
			send_word(OP_REGISTER, CH_W'($urandom), $urandom, TIME_W'($urandom_range(1, 4)), '0);
		// every slot expires in one tick: longest result train
		send_word(OP_TICK, 8'h00, 32'h0, 32'h0, 32'd1000);
		send_word(OP_CLEAR, 8'h00, 32'h0, 32'h0, 32'h0);
	endtask

	task automatic test_random_traffic(int count, logic en);
		op_t               op;
		logic [CH_W-1:0]   ch;
		logic [ID_W-1:0]   fr;
		logic [TIME_W-1:0] to;
		int                pick;
		int                slot;
		write_enable(en);
		repeat (count) begin
			pick = $urandom_range(0, 99);
			op = (pick < 30) ? OP_REGISTER : (pick < 62) ? OP_RECEIVE :
				(pick < 97) ? OP_TICK : OP_CLEAR;
			// small pools so receives and duplicates hit often
			ch = ($urandom_range(0, 9) < 7) ? CH_W'($urandom_range(0, 3)) : CH_W'($urandom);
			fr = ($urandom_range(0, 9) < 7) ? ID_W'($urandom_range(0, 3)) : ID_W'($urandom);
			if (op == OP_RECEIVE && tbl_fill > 0 && $urandom_range(0, 3) != 0) begin
				slot = $urandom_range(0, tbl_fill - 1);
				ch = tbl_channel[slot];
				fr = tbl_frame[slot];
			end
			case ($urandom_range(0, 9))
				0, 1: to = '0;
				2: to = $urandom;
				3: to = '1;
				default: to = TIME_W'($urandom_range(1, 40));
			endcase
			pick = $urandom_range(0, 49);
			if (pick == 0)
				clock_ms = $urandom;
			else if (pick == 1)
				clock_ms = 32'hFFFF_FFF0 + TIME_W'($urandom_range(0, 15));
			else
				clock_ms = clock_ms + TIME_W'($urandom_range(0, 12));
			send_word(op, ch, fr, to, clock_ms);
		end
	endtask

	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		opcode     <= OP_REGISTER;
		channel_id <= '0;
		frame_id   <= '0;
		timeout_ms <= '0;
		now_ms     <= '0;
		cfg_valid  <= 1'b0;
		cfg_data   <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_full_table();
		test_random_traffic(140, 1'b1);
		test_random_traffic(60, 1'b0);
		test_random_traffic(140, 1'b1);
		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && due_reports.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule
